[hw/rtl/pad_hit_detect_and_sequence_capture_assert.svh]
// Assertion macros for the pad hit detector.
// Included by the top level; no other dependencies.
`ifndef PAD_HIT_DETECT_AND_SEQUENCE_CAPTURE_ASSERT_SVH
`define PAD_HIT_DETECT_AND_SEQUENCE_CAPTURE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define PHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included.
`define PHD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PHD_ASSERT(label, prop, msg)
`define PHD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/phd_pkg.sv]
// Shared constants and types for the pad hit detector.
// No dependencies.
package phd_pkg;

    localparam int NUM_PADS    = 4;
    localparam int SEQ_DEPTH   = 6;
    localparam int SAMPLE_BITS = 10;

    localparam int THR_W   = 10;
    localparam int LOCK_W  = 16;
    localparam int TIME_W  = 32;
    localparam int ENTRY_W = 3;
    localparam int COUNT_W = $clog2(SEQ_DEPTH + 1);
    localparam int SLOT_W  = $clog2(SEQ_DEPTH + NUM_PADS + 1);
    localparam int IDX_W   = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int WORD_W  = ENTRY_W * SEQ_DEPTH;
    localparam int CMP_W   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIT_THRESHOLD = 1'b0,
        CFG_LOCKOUT_MS    = 1'b1
    } cfg_index_t;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(512);
    localparam logic [LOCK_W-1:0] LOCKOUT_RESET   = LOCK_W'(200);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_pad0;
        logic [SAMPLE_BITS-1:0] sample_pad1;
        logic [SAMPLE_BITS-1:0] sample_pad2;
        logic [SAMPLE_BITS-1:0] sample_pad3;
        logic [TIME_W-1:0]      now_ms;
        logic                   capture_on;
        logic                   capture_restart;
    } in_item_t;

    typedef struct packed {
        logic [NUM_PADS-1:0] pressed_mask;
        logic [NUM_PADS-1:0] trigger_mask;
        logic [NUM_PADS-1:0] appended_mask;
        logic [COUNT_W-1:0]  sequence_length;
        logic [WORD_W-1:0]   sequence_word;
    } out_item_t;

    // Broadcast to every lane.
    typedef struct packed {
        logic              accept;
        logic              active;
        logic [THR_W-1:0]  threshold;
        logic [LOCK_W-1:0] lockout_ms;
        logic [TIME_W-1:0] now_ms;
    } lane_ctl_t;

    typedef struct packed {
        logic trigger;
        logic pressed;
    } lane_res_t;

endpackage

[hw/rtl/phd_lane.sv]
// One pad lane: threshold compare, lockout timer and pressed flag.
// Depends on phd_pkg.
module phd_lane (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  phd_pkg::lane_ctl_t                   ctl,
    input  logic [phd_pkg::SAMPLE_BITS-1:0]      sample,
    output phd_pkg::lane_res_t                   res
);
    import phd_pkg::*;

    logic              pressed_reg, pressed_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              above;
    logic              unlocked;
    logic              trigger;
    logic [TIME_W-1:0] elapsed;

    always_comb begin
        above    = CMP_W'(sample) > CMP_W'(ctl.threshold);
        elapsed  = ctl.now_ms - last_time_reg;   // wraps mod 2^32
        unlocked = elapsed > TIME_W'(ctl.lockout_ms);
        trigger  = ctl.active && above && !pressed_reg && unlocked;

        pressed_next   = pressed_reg;
        last_time_next = last_time_reg;
        if (ctl.active) begin
            pressed_next = above ? (pressed_reg || trigger) : 1'b0;
        end
        if (trigger) begin
            last_time_next = ctl.now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg   <= 1'b0;
            last_time_reg <= '0;
        end else if (ctl.accept) begin
            pressed_reg   <= pressed_next;
            last_time_reg <= last_time_next;
        end
    end

    assign res.trigger = trigger;
    assign res.pressed = pressed_next;

endmodule

[hw/rtl/phd_merge.sv]
// Merge stage: appends triggered pads to the sequence in pad order.
// Depends on phd_pkg.
module phd_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic                              restart,
    input  logic [phd_pkg::NUM_PADS-1:0]      trigger_mask,
    output logic [phd_pkg::NUM_PADS-1:0]      appended_mask,
    output logic [phd_pkg::COUNT_W-1:0]       sequence_length,
    output logic [phd_pkg::WORD_W-1:0]        sequence_word
);
    import phd_pkg::*;

    logic [ENTRY_W-1:0] entries_reg [SEQ_DEPTH];
    logic [ENTRY_W-1:0] entries_next [SEQ_DEPTH];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]  slot;

    always_comb begin
        slot          = restart ? '0 : SLOT_W'(count_reg);
        appended_mask = '0;
        for (int k = 0; k < SEQ_DEPTH; k++) begin
            entries_next[k] = restart ? '0 : entries_reg[k];
        end
        // Lower pad index takes the earlier slot.
        for (int i = 0; i < NUM_PADS; i++) begin
            if (trigger_mask[i] && (slot < SLOT_W'(SEQ_DEPTH))) begin
                appended_mask[i]             = 1'b1;
                entries_next[slot[IDX_W-1:0]] = ENTRY_W'(i + 1);
                slot                         = slot + SLOT_W'(1);
            end
        end
        count_next = slot[COUNT_W-1:0];
        for (int k = 0; k < SEQ_DEPTH; k++) begin
            sequence_word[k*ENTRY_W +: ENTRY_W] = entries_next[k];
        end
    end

    assign sequence_length = count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int k = 0; k < SEQ_DEPTH; k++) begin
                entries_reg[k] <= '0;
            end
        end else if (accept) begin
            count_reg <= count_next;
            for (int k = 0; k < SEQ_DEPTH; k++) begin
                entries_reg[k] <= entries_next[k];
            end
        end
    end

endmodule

[hw/rtl/pad_hit_detect_and_sequence_capture.sv]
// Top level of the pad hit detector: config registers, lanes, merge, output buffer.
// Depends on phd_pkg, phd_lane, phd_merge and the assertion macro header.
//
// Usage:
//   s_valid/s_ready/s_data carry one sampling tick per request: four pad
//   readings, the millisecond time and the capture controls.
//   m_valid/m_ready/m_data return exactly one result per tick, in order.
//   cfg_wr_en/cfg_wr_index/cfg_wr_data write the hit threshold (index 0)
//   and the lockout time (index 1); write only while the block is idle.
// Timing:
//   A tick is evaluated in the cycle it is accepted; its result is registered
//   into the output buffer. One tick per cycle is sustained while m_ready is high: the four
//   pad lanes and the ordered append all settle within that cycle.
// Stall:
//   A two-entry output buffer holds results; s_ready drops only when both
//   entries are full, so one more tick is taken while a result waits.
// Reset:
//   aresetn low clears pressed flags, trigger times, the sequence and the
//   output buffer, and loads threshold 512 and lockout 200 ms.
`include "pad_hit_detect_and_sequence_capture_assert.svh"

module pad_hit_detect_and_sequence_capture (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  phd_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output phd_pkg::out_item_t                   m_data,
    input  logic                                 cfg_wr_en,
    input  logic [phd_pkg::CFG_IDX_W-1:0]        cfg_wr_index,
    input  logic [phd_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);
    import phd_pkg::*;

    logic [THR_W-1:0]  threshold_reg;
    logic [LOCK_W-1:0] lockout_reg;

    logic       push, pop;
    lane_ctl_t  ctl;
    lane_res_t  lane_res [NUM_PADS];
    logic [SAMPLE_BITS-1:0] samples [NUM_PADS];
    logic [NUM_PADS-1:0] trig_mask, pressed_mask, app_mask;
    logic [COUNT_W-1:0]  seq_len;
    logic [WORD_W-1:0]   seq_word;
    out_item_t result;

    out_item_t out_data_reg, skid_data_reg;
    logic      out_valid_reg, skid_valid_reg;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            lockout_reg   <= LOCKOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_wr_index))
                CFG_HIT_THRESHOLD: threshold_reg <= cfg_wr_data[THR_W-1:0];
                CFG_LOCKOUT_MS:    lockout_reg   <= cfg_wr_data[LOCK_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    assign ctl.accept     = push;
    assign ctl.active     = s_data.capture_on;
    assign ctl.threshold  = threshold_reg;
    assign ctl.lockout_ms = lockout_reg;
    assign ctl.now_ms     = s_data.now_ms;

    assign samples[0] = s_data.sample_pad0;
    assign samples[1] = s_data.sample_pad1;
    assign samples[2] = s_data.sample_pad2;
    assign samples[3] = s_data.sample_pad3;

    for (genvar i = 0; i < NUM_PADS; i++) begin : g_lane
        phd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .sample  (samples[i]),
            .res     (lane_res[i])
        );
        assign trig_mask[i]    = lane_res[i].trigger;
        assign pressed_mask[i] = lane_res[i].pressed;
    end

    phd_merge u_merge (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (push),
        .restart         (s_data.capture_restart),
        .trigger_mask    (trig_mask),
        .appended_mask   (app_mask),
        .sequence_length (seq_len),
        .sequence_word   (seq_word)
    );

    assign result.pressed_mask    = pressed_mask;
    assign result.trigger_mask    = trig_mask;
    assign result.appended_mask   = app_mask;
    assign result.sequence_length = seq_len;
    assign result.sequence_word   = seq_word;

    // Two-entry output buffer; out_* is the head, skid_* the second entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg) begin
            out_valid_reg <= push;
        end else if (pop) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= push;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || (pop && !skid_valid_reg)) begin
            if (push) begin
                out_data_reg <= result;
            end
        end else if (pop) begin
            out_data_reg <= skid_data_reg;
            if (push) begin
                skid_data_reg <= result;
            end
        end else if (push) begin
            skid_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `PHD_ASSERT(a_app_within_trig, m_valid |-> ((m_data.appended_mask & ~m_data.trigger_mask) == '0), "appended pad did not trigger")
    `PHD_ASSERT(a_len_bound, m_valid |-> (m_data.sequence_length <= COUNT_W'(SEQ_DEPTH)), "sequence length above depth")
    `PHD_ASSERT(a_skid_order, skid_valid_reg |-> out_valid_reg, "second buffer entry without head")
    `PHD_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule
